@@ design/cbvp_pkg.sv @@
// Shared types and constants for the CO2 band valve pulser.
// No dependencies; imported by every design file.
package cbvp_pkg;

   // band state codes
   localparam logic [2:0] ST_FILL     = 3'd0;
   localparam logic [2:0] ST_APPROACH = 3'd1;
   localparam logic [2:0] ST_INBAND   = 3'd2;
   localparam logic [2:0] ST_OVER     = 3'd3;
   localparam logic [2:0] ST_FALLBACK = 3'd4;
   localparam logic [2:0] ST_UNDER    = 3'd5;

   // register indexes
   localparam logic [1:0] REG_FILL_THRESHOLD   = 2'd0;
   localparam logic [1:0] REG_BAND_LOW         = 2'd1;
   localparam logic [1:0] REG_BAND_HIGH        = 2'd2;
   localparam logic [1:0] REG_INITIAL_CYCLE_MS = 2'd3;

   // register reset values
   localparam logic [13:0] FILL_THRESHOLD_RST   = 14'd400;
   localparam logic [13:0] BAND_LOW_RST         = 14'd445;
   localparam logic [13:0] BAND_HIGH_RST        = 14'd455;
   localparam logic [15:0] INITIAL_CYCLE_MS_RST = 16'd10000;

   // per-state pulse lengths and cycle periods, ms
   localparam logic [8:0]  PULSE_FILL     = 9'd500;
   localparam logic [8:0]  PULSE_INBAND   = 9'd150;
   localparam logic [8:0]  PULSE_FALLBACK = 9'd200;
   localparam logic [8:0]  PULSE_UNDER    = 9'd300;
   localparam logic [8:0]  PULSE_NONE     = 9'd0;
   localparam logic [15:0] CYCLE_OVER     = 16'd16000;
   localparam logic [15:0] CYCLE_FALLBACK = 16'd10000;

   typedef struct packed {
      logic [13:0] fill_threshold;
      logic [13:0] band_low;
      logic [13:0] band_high;
   } cbvp_thresh_type;

   // what the new band state asks of the valve timer
   typedef struct packed {
      logic        force_close;
      logic [8:0]  pulse;
      logic        set_cycle;
      logic [15:0] cycle_val;
   } cbvp_band_cmd_type;

endpackage

@@ design/co2_band_valve_pulser.sv @@
// Top level of the CO2 band valve pulser: channels, config registers,
// state and the two pipeline registers. Depends on cbvp_pkg,
// cbvp_band_next and cbvp_valve_timer.
//
// Usage
//   req_ channel: one word per sensor sample, co2_level in hundredths of a
//     percent and now_ms, a free-running 32-bit millisecond time.
//   rsp_ channel: one word per sample: valve command, band state, pulse
//     length and cycle period in force after that sample.
//   csr_ channel: register writes (index 0 fill threshold, 1 band low,
//     2 band high, 3 initial cycle period). Always ready. Write only while
//     no sample is in flight.
// Timing
//   Two register stages: a sample accepted into the input register moves
//   on to the result register, which drives rsp_. The band and timer
//   state advance as a sample leaves the input register, so one sample
//   per cycle is sustained while rsp_ready is high, set by the single
//   input-to-result pass. When rsp_ready is low the result register holds
//   and the input register fills; req_ready drops only when both are full.
// Reset
//   Synchronous, active high: band state fill, valve closed, pulse 0,
//   cycle start 0, period taken from the initial cycle register until the
//   over or falling-back state loads one; registers take their defaults.
module co2_band_valve_pulser (
   input  logic        clock,
   input  logic        reset,
   // sample words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [13:0] req_co2_level,
   input  logic [31:0] req_now_ms,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_valve_open,
   output logic [2:0]  rsp_band_state,
   output logic [8:0]  rsp_pulse_ms,
   output logic [15:0] rsp_cycle_ms,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import cbvp_pkg::*;

   // configuration
   cbvp_thresh_type thresh_ff;
   logic [15:0]     init_cycle_ff;

   // input register
   logic        in_vld_ff;
   logic [13:0] in_level_ff;
   logic [31:0] in_now_ff;

   // block state
   logic [2:0]  band_ff;
   logic        valve_ff;
   logic [8:0]  pulse_ff;
   logic [15:0] cycle_len_ff;
   logic        cycle_set_ff;
   logic [31:0] cycle_start_ff;

   // result register
   logic        out_vld_ff;
   logic        out_valve_ff;
   logic [2:0]  out_band_ff;
   logic [8:0]  out_pulse_ff;
   logic [15:0] out_cycle_ff;

   logic              advance;
   logic [2:0]        band_in;
   cbvp_band_cmd_type cmd;
   logic [15:0]       cycle_len_in;
   logic              cycle_set_in;
   logic [15:0]       period;
   logic              valve_in;
   logic              restart;

   // input register moves on when the result register can take a word
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign csr_ready = 1'b1;

   cbvp_band_next u_band (
      .cur_state  (band_ff),
      .level      (in_level_ff),
      .thresh     (thresh_ff),
      .next_state (band_in),
      .cmd        (cmd)
   );

   assign cycle_len_in = cmd.set_cycle ? cmd.cycle_val : cycle_len_ff;
   assign cycle_set_in = cycle_set_ff || cmd.set_cycle;
   assign period       = cycle_set_in ? cycle_len_in : init_cycle_ff;

   cbvp_valve_timer u_timer (
      .valve_cur   (valve_ff),
      .cycle_start (cycle_start_ff),
      .now_ms      (in_now_ff),
      .period      (period),
      .cmd         (cmd),
      .valve_next  (valve_in),
      .restart     (restart)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.fill_threshold <= FILL_THRESHOLD_RST;
         thresh_ff.band_low       <= BAND_LOW_RST;
         thresh_ff.band_high      <= BAND_HIGH_RST;
         init_cycle_ff            <= INITIAL_CYCLE_MS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FILL_THRESHOLD:   thresh_ff.fill_threshold <= csr_wdata[13:0];
            REG_BAND_LOW:         thresh_ff.band_low       <= csr_wdata[13:0];
            REG_BAND_HIGH:        thresh_ff.band_high      <= csr_wdata[13:0];
            REG_INITIAL_CYCLE_MS: init_cycle_ff            <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_level_ff <= req_co2_level;
         in_now_ff   <= req_now_ms;
      end
   end

   // block state, updated once per word
   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff        <= ST_FILL;
         valve_ff       <= 1'b0;
         pulse_ff       <= PULSE_NONE;
         cycle_len_ff   <= INITIAL_CYCLE_MS_RST;
         cycle_set_ff   <= 1'b0;
         cycle_start_ff <= '0;
      end else if (advance) begin
         band_ff      <= band_in;
         valve_ff     <= valve_in;
         pulse_ff     <= cmd.pulse;
         cycle_len_ff <= cycle_len_in;
         cycle_set_ff <= cycle_set_in;
         if (restart) begin
            cycle_start_ff <= in_now_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_valve_ff <= valve_in;
         out_band_ff  <= band_in;
         out_pulse_ff <= cmd.pulse;
         out_cycle_ff <= period;
      end
   end

   // pulse_ff is kept as state; the result copy carries it out
   assign rsp_valid      = out_vld_ff;
   assign rsp_valve_open = out_valve_ff;
   assign rsp_band_state = out_band_ff;
   assign rsp_pulse_ms   = out_vld_ff ? out_pulse_ff : pulse_ff;
   assign rsp_cycle_ms   = out_cycle_ff;

endmodule

@@ design/cbvp_band_next.sv @@
// Next band state with hysteresis and the per-state valve command.
// Depends on cbvp_pkg.
module cbvp_band_next (
   input  logic [2:0]                  cur_state,
   input  logic [13:0]                 level,
   input  cbvp_pkg::cbvp_thresh_type   thresh,
   output logic [2:0]                  next_state,
   output cbvp_pkg::cbvp_band_cmd_type cmd
);
   import cbvp_pkg::*;

   logic in_band;
   logic below_fill;

   always_comb begin
      in_band    = level inside {[thresh.band_low : thresh.band_high]};
      below_fill = level < thresh.fill_threshold;

      case (cur_state)
         ST_FILL: begin
            next_state = below_fill ? ST_FILL : ST_APPROACH;
         end
         ST_APPROACH, ST_UNDER: begin
            if (in_band)         next_state = ST_INBAND;
            else if (below_fill) next_state = ST_FILL;
            else                 next_state = cur_state;
         end
         ST_INBAND: begin
            if (level > thresh.band_high)     next_state = ST_OVER;
            else if (level < thresh.band_low) next_state = ST_UNDER;
            else                              next_state = ST_INBAND;
         end
         ST_OVER: begin
            next_state = (level <= thresh.band_high) ? ST_FALLBACK : ST_OVER;
         end
         ST_FALLBACK: begin
            if (level < thresh.band_low)       next_state = ST_UNDER;
            else if (level > thresh.band_high) next_state = ST_OVER;
            else                               next_state = ST_FALLBACK;
         end
         default: begin
            next_state = ST_FILL;
         end
      endcase

      cmd = '{force_close: 1'b0, pulse: PULSE_UNDER, set_cycle: 1'b0,
              cycle_val: CYCLE_FALLBACK};
      case (next_state)
         ST_FILL: begin
            cmd.pulse = PULSE_FILL;
         end
         ST_APPROACH: begin
            cmd.force_close = 1'b1;
            cmd.pulse       = PULSE_NONE;
         end
         ST_INBAND: begin
            cmd.force_close = 1'b1;
            cmd.pulse       = PULSE_INBAND;
         end
         ST_OVER: begin
            cmd.force_close = 1'b1;
            cmd.pulse       = PULSE_NONE;
            cmd.set_cycle   = 1'b1;
            cmd.cycle_val   = CYCLE_OVER;
         end
         ST_FALLBACK: begin
            cmd.pulse     = PULSE_FALLBACK;
            cmd.set_cycle = 1'b1;
            cmd.cycle_val = CYCLE_FALLBACK;
         end
         default: begin
            cmd.pulse = PULSE_UNDER;
         end
      endcase
   end

endmodule

@@ design/cbvp_valve_timer.sv @@
// Valve pulse/cycle timer: closes after the pulse, reopens after the period.
// Depends on cbvp_pkg.
module cbvp_valve_timer (
   input  logic                        valve_cur,
   input  logic [31:0]                 cycle_start,
   input  logic [31:0]                 now_ms,
   input  logic [15:0]                 period,
   input  cbvp_pkg::cbvp_band_cmd_type cmd,
   output logic                        valve_next,
   output logic                        restart
);
   import cbvp_pkg::*;

   logic [31:0] elapsed;
   logic        held_open;

   always_comb begin
      elapsed   = now_ms - cycle_start;   // wraps at 32 bits
      held_open = valve_cur && !cmd.force_close &&
                  !(elapsed > {23'd0, cmd.pulse});
      // forced close does not stop the timer: may reopen at once
      restart    = !held_open && (elapsed > {16'd0, period});
      valve_next = held_open || restart;
   end

endmodule

@@ tb/sv/tb_co2_band_valve_pulser.sv @@
// Self-checking testbench for co2_band_valve_pulser: directed and random
// sample words, a per-sample band/timer predictor and a result checker.
// Depends on cbvp_pkg and the co2_band_valve_pulser RTL.
`timescale 1ns / 1ps

module tb_co2_band_valve_pulser;
   import cbvp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_SAMPLES = 90;

   // one sample word on req_, one valve word on rsp_
   typedef struct packed {
      logic [13:0] co2_level;
      logic [31:0] now_ms;
   } sample_type;

   typedef struct packed {
      logic        valve_open;
      logic [2:0]  band_state;
      logic [8:0]  pulse_ms;
      logic [15:0] cycle_ms;
   } valve_word_type;

   // DUT ports, all driven to known values from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [13:0] req_co2_level = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic        rsp_valve_open;
   logic [2:0]  rsp_band_state;
   logic [8:0]  rsp_pulse_ms;
   logic [15:0] rsp_cycle_ms;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // stimulus and scoreboard storage
   sample_type     pending_samples[$];
   valve_word_type expected_words[$];
   int             fail_count = 0;
   int             results_seen = 0;
   int             cycle_count = 0;
   logic [31:0]    sample_clock_ms = '0;

   // driver burst shaping
   int burst_left = 0;
   int gap_left = 0;

   // receiver stall pattern and the one long hold-off
   logic [31:0] ready_tick = '0;
   int          hold_left = 0;
   logic        long_hold_done = 1'b0;

   // predictor copy of the registers
   logic [13:0] fill_thr;
   logic [13:0] band_lo;
   logic [13:0] band_hi;
   logic [15:0] init_cycle;
   // predictor copy of the band machine and valve timer
   logic [2:0]  band_q;
   logic        valve_q;
   logic [8:0]  pulse_q;
   logic [15:0] cycle_q;
   logic        cycle_loaded;   // over/falling-back has loaded cycle_q
   logic [31:0] cycle_start_q;

   co2_band_valve_pulser DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_co2_level  (req_co2_level),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_valve_open (rsp_valve_open),
      .rsp_band_state (rsp_band_state),
      .rsp_pulse_ms   (rsp_pulse_ms),
      .rsp_cycle_ms   (rsp_cycle_ms),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   // Hysteresis band machine. Thresholds are compared exactly as programmed,
   // so an inverted band (low above high) simply never counts as in band.
   function automatic logic [2:0] next_band(input logic [2:0] cur, input logic [13:0] lvl);
      logic in_band;
      in_band = (lvl >= band_lo) && (lvl <= band_hi);
      case (cur)
         ST_FILL: begin
            return (lvl >= fill_thr) ? ST_APPROACH : ST_FILL;
         end
         ST_APPROACH, ST_UNDER: begin
            if (in_band) return ST_INBAND;
            if (lvl < fill_thr) return ST_FILL;
            return cur;
         end
         ST_INBAND: begin
            if (lvl > band_hi) return ST_OVER;
            if (lvl < band_lo) return ST_UNDER;
            return cur;
         end
         ST_OVER: begin
            return (lvl <= band_hi) ? ST_FALLBACK : ST_OVER;
         end
         ST_FALLBACK: begin
            if (lvl < band_lo) return ST_UNDER;
            if (lvl > band_hi) return ST_OVER;
            return cur;
         end
         default: begin
            return ST_FILL;   // unused codes fall back to fill
         end
      endcase
   endfunction

   // Advances the predicted band and timer state by one sample and returns
   // the valve word the block must produce for it.
   function automatic valve_word_type advance_pulser(input sample_type s);
      logic [15:0] period;
      logic [31:0] elapsed;
      valve_word_type w;
      band_q = next_band(band_q, s.co2_level);
      case (band_q)
         ST_FILL: begin
            pulse_q = PULSE_FILL;
         end
         ST_APPROACH: begin
            valve_q = 1'b0;
            pulse_q = PULSE_NONE;
         end
         ST_INBAND: begin
            valve_q = 1'b0;
            pulse_q = PULSE_INBAND;
         end
         ST_OVER: begin
            valve_q = 1'b0;
            pulse_q = PULSE_NONE;
            cycle_q = CYCLE_OVER;
            cycle_loaded = 1'b1;
         end
         ST_FALLBACK: begin
            pulse_q = PULSE_FALLBACK;
            cycle_q = CYCLE_FALLBACK;
            cycle_loaded = 1'b1;
         end
         default: begin
            pulse_q = PULSE_UNDER;
         end
      endcase
      period = cycle_loaded ? cycle_q : init_cycle;
      // wrapping 32-bit elapsed time; a forced close can reopen at once
      elapsed = s.now_ms - cycle_start_q;
      if (valve_q && elapsed > {23'd0, pulse_q})
         valve_q = 1'b0;
      if (!valve_q && elapsed > {16'd0, period}) begin
         valve_q = 1'b1;
         cycle_start_q = s.now_ms;
      end
      w.valve_open = valve_q;
      w.band_state = band_q;
      w.pulse_ms = pulse_q;
      w.cycle_ms = period;
      return w;
   endfunction

   // Sender: bursts of random length with random gaps. Valid holds with a
   // stable payload until accepted; back-to-back words keep valid high.
   always @(posedge clock) begin
      sample_type s;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!(req_valid && !req_ready)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            s = pending_samples.pop_front();
            req_valid <= 1'b1;
            req_co2_level <= s.co2_level;
            req_now_ms <= s.now_ms;
            if (burst_left > 0)
               burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               // a quarter of the bursts run straight into the next one
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: the stall pattern steps through always ready, coin flip,
   // mostly ready and a repeating on/off pattern. Once, mid-run with plenty of
   // words still queued, it holds off long enough to back up the input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         ready_tick = '0;
         hold_left = 0;
      end else begin
         ready_tick++;
         if (!long_hold_done && results_seen >= 150 && pending_samples.size() > 40) begin
            hold_left = 150;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (ready_tick[8:7])
               2'd0: rsp_ready <= 1'b1;
               2'd1: rsp_ready <= 1'($urandom_range(0, 1));
               2'd2: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= (ready_tick[2:0] < 3'd3);
            endcase
         end
      end
   end

   // Monitor: checks each accepted valve word against the oldest prediction,
   // predicts for each accepted sample word, and mirrors register writes.
   always @(posedge clock) begin
      valve_word_type got;
      valve_word_type want;
      if (reset) begin
         fill_thr = FILL_THRESHOLD_RST;
         band_lo = BAND_LOW_RST;
         band_hi = BAND_HIGH_RST;
         init_cycle = INITIAL_CYCLE_MS_RST;
         band_q = ST_FILL;
         valve_q = 1'b0;
         pulse_q = PULSE_NONE;
         cycle_q = INITIAL_CYCLE_MS_RST;
         cycle_loaded = 1'b0;
         cycle_start_q = '0;
         expected_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            got.valve_open = rsp_valve_open;
            got.band_state = rsp_band_state;
            got.pulse_ms = rsp_pulse_ms;
            got.cycle_ms = rsp_cycle_ms;
            if (expected_words.size() == 0) begin
               $error("unexpected valve word: valve_open %0d band_state %0d pulse_ms %0d cycle_ms %0d",
                      got.valve_open, got.band_state, got.pulse_ms, got.cycle_ms);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (got.valve_open !== want.valve_open) begin
                  $error("valve_open: expected %0d, got %0d", want.valve_open, got.valve_open);
                  fail_count++;
               end
               if (got.band_state !== want.band_state) begin
                  $error("band_state: expected %0d, got %0d", want.band_state, got.band_state);
                  fail_count++;
               end
               if (got.pulse_ms !== want.pulse_ms) begin
                  $error("pulse_ms: expected %0d, got %0d", want.pulse_ms, got.pulse_ms);
                  fail_count++;
               end
               if (got.cycle_ms !== want.cycle_ms) begin
                  $error("cycle_ms: expected %0d, got %0d", want.cycle_ms, got.cycle_ms);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_words.push_back(advance_pulser({req_co2_level, req_now_ms}));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FILL_THRESHOLD:   fill_thr = csr_wdata[13:0];
               REG_BAND_LOW:         band_lo = csr_wdata[13:0];
               REG_BAND_HIGH:        band_hi = csr_wdata[13:0];
               REG_INITIAL_CYCLE_MS: init_cycle = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Called at a rising edge; returns at the rising edge after the one at
   // which the write is taken.
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Full register set; the 14-bit registers get random junk in the two
   // unused top bits, which the block must drop.
   task automatic program_regs(input logic [13:0] fill, input logic [13:0] lo,
                               input logic [13:0] hi, input logic [15:0] init);
      logic [1:0] junk;
      junk = 2'($urandom_range(0, 3));
      write_reg(REG_FILL_THRESHOLD, {junk, fill});
      junk = 2'($urandom_range(0, 3));
      write_reg(REG_BAND_LOW, {junk, lo});
      junk = 2'($urandom_range(0, 3));
      write_reg(REG_BAND_HIGH, {junk, hi});
      write_reg(REG_INITIAL_CYCLE_MS, init);
   endtask

   task automatic add_sample(input logic [13:0] lvl, input logic [31:0] t);
      sample_type s;
      s.co2_level = lvl;
      s.now_ms = t;
      pending_samples.push_back(s);
      sample_clock_ms = t;
   endtask

   // Random readings cluster around the programmed thresholds so the band
   // machine keeps crossing edges; one in ten is anywhere in 14 bits.
   // Time mostly advances by realistic steps, sometimes stands still or
   // jumps anywhere (which also exercises wrap-around).
   task automatic queue_random(input int count);
      int          v;
      int unsigned pick;
      logic [13:0] base;
      logic [31:0] step;
      repeat (count) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            v = $urandom_range(0, 16383);
         end else begin
            base = (pick <= 3) ? fill_thr : (pick <= 6) ? band_lo : band_hi;
            v = int'(base) + int'($urandom_range(0, 16)) - 8;
            if (v < 0) v = 0;
            if (v > 16383) v = 16383;
         end
         pick = $urandom_range(0, 19);
         if (pick == 0)
            step = '0;
         else if (pick == 1)
            step = $urandom();
         else if (pick < 10)
            step = $urandom_range(1, 600);
         else
            step = $urandom_range(600, 4000);
         add_sample(v[13:0], sample_clock_ms + step);
      end
   endtask

   // Sampled at the falling edge so the driver and monitor have settled;
   // returns on a rising edge, ready to drive.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_words.size() != 0);
      @(posedge clock);
   endtask

   initial begin
      logic [13:0] fill;
      logic [13:0] lo;
      logic [13:0] hi;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: fill-state pulse opening, closing after 500 ms,
      // then approach forcing the valve shut and, with the period already
      // run out, reopening in the same step.
      add_sample(14'd0, 32'd0);
      add_sample(14'd0, 32'd10001);
      add_sample(14'd100, 32'd10502);
      add_sample(14'd16383, 32'd10600);
      add_sample(14'd420, 32'd20602);
      wait_idle();

      // Zero period and zero fill threshold: reopens on any elapsed time.
      write_reg(REG_INITIAL_CYCLE_MS, 16'd0);
      write_reg(REG_FILL_THRESHOLD, 16'd0);
      add_sample(14'd5000, 32'd20800);
      add_sample(14'd0, 32'd20800);
      add_sample(14'd450, 32'd20802);
      add_sample(14'd440, 32'd30000);
      add_sample(14'd16383, 32'd30100);
      wait_idle();

      // Top-of-range threshold (upper bits of the write must be dropped)
      // and the longest initial period.
      write_reg(REG_FILL_THRESHOLD, 16'hFFFF);
      write_reg(REG_INITIAL_CYCLE_MS, 16'hFFFF);
      add_sample(14'd600, 32'd30300);
      add_sample(14'd16383, 32'd30400);
      add_sample(14'd100, 32'd130400);
      wait_idle();

      // Defaults back: walk every band state but fill across the 32-bit time wrap.
      program_regs(FILL_THRESHOLD_RST, BAND_LOW_RST, BAND_HIGH_RST, INITIAL_CYCLE_MS_RST);
      add_sample(14'd450, 32'hFFFF_F000);
      add_sample(14'd450, 32'hFFFF_F100);
      add_sample(14'd456, 32'hFFFF_FF00);
      add_sample(14'd455, 32'h0000_0100);
      add_sample(14'd456, 32'h0000_3000);
      add_sample(14'd450, 32'h0000_4000);
      add_sample(14'd444, 32'h0000_8000);
      add_sample(14'd445, 32'h0000_9000);
      add_sample(14'd399, 32'h0000_A000);
      wait_idle();

      // Inverted band: never in band, under can only fall back to fill.
      write_reg(REG_BAND_LOW, 16'd600);
      write_reg(REG_BAND_HIGH, 16'd500);
      add_sample(14'd550, 32'h0000_C000);
      add_sample(14'd399, 32'h0001_0000);
      wait_idle();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               fill = 14'($urandom_range(300, 450));
               lo = fill + 14'($urandom_range(0, 60));
               hi = lo + 14'($urandom_range(0, 30));
               program_regs(fill, lo, hi, 16'($urandom_range(0, 65535)));
            end
            1: program_regs(14'd0, 14'd0, 14'h3FFF, 16'hFFFF);
            2: program_regs(14'd10000, 14'd10000, 14'd10000, 16'd0);
            3: program_regs(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                            14'($urandom_range(0, 16383)), 16'($urandom_range(0, 65535)));
            default: begin
               hi = 14'($urandom_range(200, 600));
               lo = hi + 14'($urandom_range(1, 40));
               program_regs(14'($urandom_range(100, 500)), lo, hi,
                            16'($urandom_range(0, 65535)));
            end
         endcase
         queue_random(PHASE_SAMPLES);
         wait_idle();
      end

      // let any stray word show up before the verdict
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
